FILE: rtl/ddo_pkg.sv
// shared types, constants and tables for the differential drive odometry block
package ddo_pkg;

	// cordic iteration count, the step index width that follows from it and the angle table index width
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
	localparam int ATAN_IDX_W   = 5;

	// cordic start value (limit gain at 2^30) and radians to binary angle in q.8
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
	localparam logic [21:0]        RAD_TO_BAM  = 22'd2670177;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_BASELINE = 1'd1;

	// reset values of the configuration registers
	localparam logic [15:0] WHEEL_RADIUS_RST = 16'd3277;
	localparam logic [15:0] INV_BASELINE_RST = 16'd1280;

	// shared multiplier operand widths
	localparam int MUL_A_W = 41;
	localparam int MUL_B_W = 23;
	localparam int MUL_P_W = 64;

	// input item
	typedef struct packed {
		logic signed [15:0] left_wheel_rate;
		logic signed [15:0] right_wheel_rate;
		logic [15:0]        tick_length;
	} ddo_in_t;

	// result item
	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic [15:0]        heading;
	} ddo_out_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CORDIC,
		ST_M1,
		ST_M2,
		ST_M3,
		ST_M4,
		ST_M5,
		ST_M6,
		ST_M7,
		ST_M8,
		ST_M9,
		ST_FIN
	} ddo_state_t;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_CORDIC,
		OP_M1,
		OP_M2,
		OP_M3,
		OP_M4,
		OP_M5,
		OP_M6,
		OP_M7,
		OP_M8,
		OP_M9,
		OP_FIN
	} ddo_op_t;

	// controller to datapath
	typedef struct packed {
		ddo_op_t           op;
		logic [STEP_W-1:0] step;
	} ddo_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_full;
	} ddo_status_t;

	// arctangent of 2^-i as a 32-bit binary angle
	function automatic logic [29:0] atan_bam(input logic [ATAN_IDX_W-1:0] idx);
		logic [29:0] v;
		case (idx)
			5'd0:    v = 30'd536870912;
			5'd1:    v = 30'd316933406;
			5'd2:    v = 30'd167458907;
			5'd3:    v = 30'd85004756;
			5'd4:    v = 30'd42667331;
			5'd5:    v = 30'd21354465;
			5'd6:    v = 30'd10679838;
			5'd7:    v = 30'd5340245;
			5'd8:    v = 30'd2670163;
			5'd9:    v = 30'd1335087;
			5'd10:   v = 30'd667544;
			5'd11:   v = 30'd333772;
			5'd12:   v = 30'd166886;
			5'd13:   v = 30'd83443;
			5'd14:   v = 30'd41722;
			5'd15:   v = 30'd20861;
			5'd16:   v = 30'd10430;
			5'd17:   v = 30'd5215;
			5'd18:   v = 30'd2608;
			5'd19:   v = 30'd1304;
			5'd20:   v = 30'd652;
			5'd21:   v = 30'd326;
			5'd22:   v = 30'd163;
			5'd23:   v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/ddo_cordic.sv
// iterative rotation-mode cordic giving cosine and sine of the heading in q1.16
module ddo_cordic import ddo_pkg::*; (
	input  logic                clk,
	input  logic                init,
	input  logic                step_en,
	input  logic [STEP_W-1:0]   step,
	input  logic [15:0]         heading,
	output logic signed [17:0]  cos_val,
	output logic signed [17:0]  sin_val
);

	logic signed [31:0] x_q;
	logic signed [31:0] y_q;
	logic signed [31:0] z_q;
	logic               flip_q;

	logic               flip_d;
	logic signed [31:0] dx;
	logic signed [31:0] dy;
	logic signed [31:0] atan_v;
	logic signed [32:0] x_rnd;
	logic signed [32:0] y_rnd;
	logic signed [17:0] x_mag;
	logic signed [17:0] y_mag;

	// second and third quadrant are turned by half a circle
	assign flip_d = heading[15] ^ heading[14];

	// shifted terms and angle table entry for this iteration
	assign dx     = y_q >>> step;
	assign dy     = x_q >>> step;
	assign atan_v = {2'b00, atan_bam(ATAN_IDX_W'(step))};

	// rotation state
	always_ff @(posedge clk) begin
		if (init) begin
			flip_q <= flip_d;
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= {heading[15] ^ flip_d, heading[14:0], 16'b0};
		end else if (step_en) begin
			if (!z_q[31]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_v;
			end
		end
	end

	// round from 2^30 to 2^16 and undo the half turn
	assign x_rnd   = {x_q[31], x_q} + 33'sd8192;
	assign y_rnd   = {y_q[31], y_q} + 33'sd8192;
	assign x_mag   = x_rnd[31:14];
	assign y_mag   = y_rnd[31:14];
	assign cos_val = flip_q ? -x_mag : x_mag;
	assign sin_val = flip_q ? -y_mag : y_mag;

endmodule

FILE: rtl/ddo_datapath.sv
// pose datapath: config registers, shared multiplier, rounding, pose and output register
module ddo_datapath import ddo_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ddo_cmd_t              cmd,
	output ddo_status_t           status,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [15:0]           cfg_data,
	input  ddo_in_t               in_item,
	output logic                  out_valid,
	input  logic                  out_stall,
	output ddo_out_t              out_item
);

	logic [15:0]               rad_q;
	logic [15:0]               ib_q;
	logic signed [31:0]        x_q;
	logic signed [31:0]        y_q;
	logic [15:0]               heading_q;
	logic                      out_valid_q;
	ddo_out_t                  out_q;

	logic signed [16:0]        sum_q;
	logic signed [16:0]        diff_q;
	logic [15:0]               dt_q;
	logic signed [MUL_P_W-1:0] prod_q;
	logic signed [17:0]        cos_q;
	logic signed [17:0]        sin_q;
	logic signed [39:0]        dist_q;
	logic signed [32:0]        w_q;
	logic signed [25:0]        dx_q;
	logic signed [25:0]        dy_q;
	logic signed [40:0]        turn_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] prod_d;
	logic signed [17:0]        cos_val;
	logic signed [17:0]        sin_val;
	logic signed [49:0]        rnd9;
	logic signed [49:0]        rnd16;
	logic signed [58:0]        rnd32;
	logic signed [49:0]        rnd8;
	logic [47:0]               rnd_bam;
	logic [15:0]               heading_d;
	logic signed [32:0]        x_sum;
	logic signed [32:0]        y_sum;
	logic signed [31:0]        x_sat;
	logic signed [31:0]        y_sat;

	// sine and cosine of the heading before this item's turn
	ddo_cordic u_cordic (
		.clk     (clk),
		.init    (cmd.op == OP_LOAD),
		.step_en (cmd.op == OP_CORDIC),
		.step    (cmd.step),
		.heading (heading_q),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_M1: begin
				mul_a = MUL_A_W'(sum_q);
				mul_b = MUL_B_W'({1'b0, rad_q});
			end
			OP_M2: begin
				mul_a = MUL_A_W'($signed(prod_q[32:0]));
				mul_b = MUL_B_W'({1'b0, dt_q});
			end
			OP_M3: begin
				mul_a = MUL_A_W'(diff_q);
				mul_b = MUL_B_W'({1'b0, rad_q});
			end
			OP_M4: begin
				mul_a = MUL_A_W'($signed(prod_q[32:0]));
				mul_b = MUL_B_W'({1'b0, ib_q});
			end
			OP_M5: begin
				mul_a = MUL_A_W'(dist_q);
				mul_b = MUL_B_W'(cos_q);
			end
			OP_M6: begin
				mul_a = MUL_A_W'(dist_q);
				mul_b = MUL_B_W'(sin_q);
			end
			OP_M7: begin
				mul_a = MUL_A_W'(w_q);
				mul_b = MUL_B_W'({1'b0, dt_q});
			end
			OP_M9: begin
				mul_a = turn_q;
				mul_b = MUL_B_W'({1'b0, RAD_TO_BAM});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_d = mul_a * mul_b;

	// round half up of the previous product at each scale
	assign rnd9    = {prod_q[48], prod_q[48:0]} + 50'sd256;
	assign rnd16   = {prod_q[48], prod_q[48:0]} + 50'sd32768;
	assign rnd32   = {prod_q[57], prod_q[57:0]} + 59'sd2147483648;
	assign rnd8    = {prod_q[48], prod_q[48:0]} + 50'sd128;
	assign rnd_bam = prod_q[47:0] + 48'd2147483648;

	// heading wraps modulo a full turn
	assign heading_d = heading_q + rnd_bam[47:32];

	// saturating position update
	assign x_sum = {x_q[31], x_q} + {{7{dx_q[25]}}, dx_q};
	assign y_sum = {y_q[31], y_q} + {{7{dy_q[25]}}, dy_q};
	assign x_sat = (x_sum[32] != x_sum[31]) ?
		(x_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : x_sum[31:0];
	assign y_sat = (y_sum[32] != y_sum[31]) ?
		(y_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff) : y_sum[31:0];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q <= WHEEL_RADIUS_RST;
			ib_q  <= INV_BASELINE_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_WHEEL_RADIUS: rad_q <= cfg_data;
				REG_INV_BASELINE: ib_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// kept pose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			heading_q <= '0;
		end else if (cmd.op == OP_M8) begin
			x_q <= x_sat;
			y_q <= y_sat;
		end else if (cmd.op == OP_FIN) begin
			heading_q <= heading_d;
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_FIN) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				sum_q  <= 17'(in_item.left_wheel_rate) + 17'(in_item.right_wheel_rate);
				diff_q <= 17'(in_item.right_wheel_rate) - 17'(in_item.left_wheel_rate);
				dt_q   <= in_item.tick_length;
			end
			OP_M1: begin
				prod_q <= prod_d;
				cos_q  <= cos_val;
				sin_q  <= sin_val;
			end
			OP_M2, OP_M4, OP_M9: begin
				prod_q <= prod_d;
			end
			OP_M3: begin
				prod_q <= prod_d;
				dist_q <= rnd9[48:9];
			end
			OP_M5: begin
				prod_q <= prod_d;
				w_q    <= rnd16[48:16];
			end
			OP_M6: begin
				prod_q <= prod_d;
				dx_q   <= rnd32[57:32];
			end
			OP_M7: begin
				prod_q <= prod_d;
				dy_q   <= rnd32[57:32];
			end
			OP_M8: begin
				turn_q <= rnd8[48:8];
			end
			OP_FIN: begin
				out_q.pos_x   <= x_q;
				out_q.pos_y   <= y_q;
				out_q.heading <= heading_d;
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign out_item        = out_q;
	assign status.out_full = out_valid_q;

endmodule

FILE: rtl/ddo_ctrl.sv
// sequencing state machine for one odometry update
module ddo_ctrl import ddo_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        out_stall,
	input  ddo_status_t status,
	output ddo_cmd_t    cmd
);

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

	ddo_state_t        state_q;
	ddo_state_t        state_d;
	logic [STEP_W-1:0] step_q;
	logic              can_fin;

	// the result may load when the output register is free or being emptied
	assign can_fin = !status.out_full || !out_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// cordic iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == ST_CORDIC) begin
			step_q <= step_q + 1'b1;
		end else begin
			step_q <= '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_CORDIC;
			ST_CORDIC: if (step_q == LAST_STEP) state_d = ST_M1;
			ST_M1:     state_d = ST_M2;
			ST_M2:     state_d = ST_M3;
			ST_M3:     state_d = ST_M4;
			ST_M4:     state_d = ST_M5;
			ST_M5:     state_d = ST_M6;
			ST_M6:     state_d = ST_M7;
			ST_M7:     state_d = ST_M8;
			ST_M8:     state_d = ST_M9;
			ST_M9:     state_d = ST_FIN;
			ST_FIN:    if (can_fin) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// datapath commands
	always_comb begin
		cmd.step = step_q;
		cmd.op   = OP_NONE;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.op   = in_valid ? OP_LOAD : OP_NONE;
			end
			ST_CORDIC: cmd.op = OP_CORDIC;
			ST_M1:     cmd.op = OP_M1;
			ST_M2:     cmd.op = OP_M2;
			ST_M3:     cmd.op = OP_M3;
			ST_M4:     cmd.op = OP_M4;
			ST_M5:     cmd.op = OP_M5;
			ST_M6:     cmd.op = OP_M6;
			ST_M7:     cmd.op = OP_M7;
			ST_M8:     cmd.op = OP_M8;
			ST_M9:     cmd.op = OP_M9;
			ST_FIN:    cmd.op = can_fin ? OP_FIN : OP_NONE;
			default:   cmd.op = OP_NONE;
		endcase
	end

endmodule

FILE: rtl/differential_drive_odometry.sv
// top level of the differential drive dead-reckoning odometry block
//
//   channel  handshake             payload                 direction
//   in       in_valid / in_stall   in_item  (ddo_in_t)     wheel rates and tick length
//   out      out_valid / out_stall out_item (ddo_out_t)    new x, y and heading
//   cfg      cfg_wr_en             cfg_index, cfg_data     radius, inverse baseline
//
// one item passes through load, the cordic iterations, nine steps (the products of
// the one shared multiplier and the pose update), and the final commit
// the next item is accepted the cycle after the result is loaded
// the result waits in an output register; a stalled result holds only the final
// commit of the next item
// reset clears the pose to zero and loads the default radius and inverse baseline
module differential_drive_odometry import ddo_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ddo_in_t              in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output ddo_out_t             out_item,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	ddo_cmd_t    cmd;
	ddo_status_t status;

	// sequencer
	ddo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic and pose
	ddo_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

FILE: rtl/ddo_checker.sv
// port-level checks for the odometry block and their binding
module ddo_checker import ddo_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input ddo_in_t              in_item,
	input logic                 out_valid,
	input logic                 out_stall,
	input ddo_out_t             out_item,
	input logic                 cfg_wr_en,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [15:0]          cfg_data
);

	// a stalled result stays and holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result item dropped or changed");

	// after an item is taken the block is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled while item in work");

	// a new result only appears while an item is in work
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result item without an item in work");

	// a stalled input item stays and holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_item))
		else $error("stalled input item dropped or changed");

	// registers are written only while the block is idle and empty
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr_en |-> !in_stall && !out_valid && !$isunknown({cfg_index, cfg_data}))
		else $error("register write while an item is in work");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (.*);

FILE: verif/tb.sv
// testbench for the differential drive odometry block: pose prediction and result checking
`timescale 1ns / 1ps

module tb import ddo_pkg::*; ();

	localparam int CYCLE_LIMIT = 1000000;
	localparam longint POS_MAX = 64'sd2147483647;
	localparam longint POS_MIN = -64'sd2147483648;

	// pose predictor with its own copy of the registers and the pose
	class pose_tracker;
		longint radius;
		longint inv_base;
		longint x_pos;
		longint y_pos;
		logic [15:0] head;
		longint arc_step[24];
		ddo_out_t expected_poses[$];
		int mismatch_count;
		int checked_count;

		function new();
			radius = 3277;
			inv_base = 1280;
			x_pos = 0;
			y_pos = 0;
			head = '0;
			mismatch_count = 0;
			checked_count = 0;
			arc_step = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
				10679838, 5340245, 2670163, 1335087, 667544, 333772,
				166886, 83443, 41722, 20861, 10430, 5215,
				2608, 1304, 652, 326, 163, 81};
		endfunction

		function longint round_off(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint clamp32(longint v);
			if (v > POS_MAX)
				return POS_MAX;
			if (v < POS_MIN)
				return POS_MIN;
			return v;
		endfunction

		function void set_regs(logic [15:0] r, logic [15:0] ib);
			radius = longint'(r);
			inv_base = longint'(ib);
		endfunction

		// advance the pose by one accepted item and queue the new pose
		function void note_tick(ddo_in_t t);
			logic [31:0] ang;
			logic flip;
			longint cx, cy, cz, dx, dy;
			longint lw, rw, dt, travel, w, turn, dbam;
			ddo_out_t pose;

			// cordic on the old heading, folded into the right half plane
			ang = {head, 16'h0000};
			flip = (ang[31:30] == 2'b01) || (ang[31:30] == 2'b10);
			if (flip)
				ang = ang + 32'h8000_0000;
			cz = longint'($signed(ang));
			cx = 652032874;
			cy = 0;
			for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
				dx = cy >>> i;
				dy = cx >>> i;
				if (cz >= 0) begin
					cx = cx - dx;
					cy = cy + dy;
					cz = cz - arc_step[i];
				end else begin
					cx = cx + dx;
					cy = cy - dy;
					cz = cz + arc_step[i];
				end
			end
			cx = round_off(cx, 14);
			cy = round_off(cy, 14);
			if (flip) begin
				cx = -cx;
				cy = -cy;
			end

			// distance along the old heading
			lw = longint'($signed(t.left_wheel_rate));
			rw = longint'($signed(t.right_wheel_rate));
			dt = longint'(t.tick_length);
			travel = round_off((lw + rw) * radius * dt, 9);
			x_pos = clamp32(x_pos + round_off(travel * cx, 32));
			y_pos = clamp32(y_pos + round_off(travel * cy, 32));

			// heading change, wrapping both ways
			w = round_off((rw - lw) * radius * inv_base, 16);
			turn = round_off(w * dt, 8);
			dbam = round_off(turn * 2670177, 32);
			head = head + dbam[15:0];

			pose.pos_x = x_pos[31:0];
			pose.pos_y = y_pos[31:0];
			pose.heading = head;
			expected_poses.push_back(pose);
		endfunction

		// compare a result with the oldest expected pose
		function void check_pose(ddo_out_t got);
			ddo_out_t want;
			if (expected_poses.size() == 0) begin
				$display("%0t: unexpected result x=%0d y=%0d heading=%0d", $time,
					got.pos_x, got.pos_y, got.heading);
				mismatch_count++;
				return;
			end
			want = expected_poses.pop_front();
			checked_count++;
			if (got.pos_x !== want.pos_x) begin
				$display("%0t: pos_x expected %0d, got %0d", $time, want.pos_x, got.pos_x);
				mismatch_count++;
			end
			if (got.pos_y !== want.pos_y) begin
				$display("%0t: pos_y expected %0d, got %0d", $time, want.pos_y, got.pos_y);
				mismatch_count++;
			end
			if (got.heading !== want.heading) begin
				$display("%0t: heading expected %0d, got %0d", $time, want.heading,
					got.heading);
				mismatch_count++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ddo_in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ddo_out_t out_item;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_WHEEL_RADIUS;
	logic [15:0] cfg_data = '0;

	pose_tracker board = new();

	int cycle_count = 0;
	int ticks_sent = 0;
	int reg_settings = 1;
	int burst_left = 0;
	int gap_max = 3;
	int stall_pct = 30;
	int stall_run_max = 3;
	int stall_left = 0;
	bit valid_held = 1'b0;

	differential_drive_odometry i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d poses outstanding", $time,
				board.expected_poses.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver stall pattern in runs of random length
	always @(posedge clk) begin
		if (stall_left == 0) begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
			stall_left = $urandom_range(1, stall_run_max);
		end else begin
			stall_left--;
		end
	end

	// result checking
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_pose(out_item);
	end

	function automatic ddo_in_t tick_of(int l, int r, int dt);
		ddo_in_t t;
		t.left_wheel_rate = l[15:0];
		t.right_wheel_rate = r[15:0];
		t.tick_length = dt[15:0];
		return t;
	endfunction

	// send one item, then maybe close the burst with a gap
	task automatic drive_tick(input ddo_in_t t);
		int gap;
		in_item <= t;
		in_valid <= 1'b1;
		valid_held = 1'b1;
		do @(posedge clk); while (in_stall);
		board.note_tick(t);
		ticks_sent++;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				valid_held = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// drop valid, let every pose come back, then write both registers
	task automatic write_regs(input logic [15:0] r, input logic [15:0] ib);
		if (valid_held) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
		end
		while (board.expected_poses.size() != 0)
			@(posedge clk);
		repeat (CORDIC_STEPS + 16) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_WHEEL_RADIUS;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= REG_INV_BASELINE;
		cfg_data <= ib;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_regs(r, ib);
		reg_settings++;
	endtask

	// turn on the spot until the heading is near the aim
	task automatic steer_to(input logic [15:0] aim);
		logic [15:0] off;
		off = board.head - aim;
		for (int k = 0; k < 300 && off > 16'd2500 && off < 16'd63036; k++) begin
			drive_tick(tick_of(-1500, 1500, $urandom_range(1, 256)));
			off = board.head - aim;
		end
	endtask

	// full speed straight ahead until the chosen coordinates sit at their limits
	task automatic drive_straight(input bit use_x, input longint x_goal,
		input bit use_y, input longint y_goal);
		int rate;
		int hold;
		hold = 3;
		for (int k = 0; k < 800 && hold > 0; k++) begin
			rate = 32767 - $urandom_range(0, 300);
			drive_tick(tick_of(rate, rate, 65535 - $urandom_range(0, 300)));
			if ((!use_x || board.x_pos == x_goal) && (!use_y || board.y_pos == y_goal))
				hold--;
		end
	endtask

	// one register setting with random items and its own idle pattern
	task automatic run_phase(input logic [15:0] r, input logic [15:0] ib, input int n,
		input int gmax, input int spct, input int srun);
		ddo_in_t t;
		int pick;
		int mag;
		write_regs(r, ib);
		gap_max = gmax;
		stall_pct = spct;
		stall_run_max = srun;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(0, 9);
			t = ddo_in_t'(48'({$urandom, $urandom}));
			case (pick)
				4, 5: begin
					t.left_wheel_rate = 16'($urandom_range(0, 4096) - 2048);
					t.right_wheel_rate = 16'($urandom_range(0, 4096) - 2048);
					t.tick_length = 16'($urandom_range(0, 2048));
				end
				6: begin
					t.right_wheel_rate = t.left_wheel_rate;
				end
				7: begin
					mag = $urandom_range(0, 4);
					t.left_wheel_rate = (mag == 0) ? 16'sh8000 : (mag == 1) ? 16'sh7fff :
						(mag == 2) ? 16'sh0000 : (mag == 3) ? 16'shffff : 16'sh0001;
					mag = $urandom_range(0, 4);
					t.right_wheel_rate = (mag == 0) ? 16'sh8000 : (mag == 1) ? 16'sh7fff :
						(mag == 2) ? 16'sh0000 : (mag == 3) ? 16'shffff : 16'sh0001;
					mag = $urandom_range(0, 3);
					t.tick_length = (mag == 0) ? 16'h0000 : (mag == 1) ? 16'h0001 :
						(mag == 2) ? 16'hffff : 16'h8000;
				end
				8, 9: begin
					t.left_wheel_rate = 16'($urandom_range(0, 16384) - 8192);
					t.right_wheel_rate = 16'($urandom_range(0, 16384) - 8192);
				end
				default: ;
			endcase
			drive_tick(t);
		end
	endtask

	// stimulus
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items under the reset register values
		drive_tick(tick_of(0, 0, 0));
		drive_tick(tick_of(32767, 32767, 65535));
		drive_tick(tick_of(-32768, -32768, 65535));
		drive_tick(tick_of(-32768, 32767, 65535));
		drive_tick(tick_of(32767, -32768, 65535));
		drive_tick(tick_of(32767, -32768, 65535));
		drive_tick(tick_of(256, 256, 6554));
		drive_tick(tick_of(1000, -1000, 0));
		drive_tick(tick_of(-1, 1, 1));
		drive_tick(tick_of(1, -1, 1));
		drive_tick(tick_of(0, 0, 65535));
		repeat (5) drive_tick(tick_of(-3000, 3000, 30000));
		drive_tick(tick_of(4000, 4000, 40000));
		drive_tick(tick_of(-32768, 32767, 1));
		drive_tick(tick_of(32767, 32767, 1));
		drive_tick(tick_of(-32768, -32768, 1));

		// long straight drives into the position limits
		write_regs(16'd65535, 16'd1280);
		gap_max = 3;
		stall_pct = 30;
		stall_run_max = 4;
		steer_to(16'd32768);
		drive_straight(1'b1, POS_MIN, 1'b0, 0);
		steer_to(16'd16384);
		drive_straight(1'b0, 0, 1'b1, POS_MAX);

		// random items across register settings and idle patterns
		run_phase(16'd65535, 16'd65535, 55, 0, 0, 1);
		run_phase(16'd1, 16'd1, 55, 3, 30, 3);
		run_phase(16'd0, 16'd1280, 40, 12, 60, 20);
		run_phase(16'd3277, 16'd0, 40, 3, 30, 3);
		run_phase(16'd65535, 16'd1, 55, 12, 0, 1);
		run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 55, 0, 60,
			20);
		run_phase(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)), 55, 3, 30,
			3);
		run_phase(16'd1, 16'd65535, 55, 12, 60, 20);

		// drain
		if (valid_held) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
		end
		while (board.expected_poses.size() != 0)
			@(posedge clk);
		repeat (CORDIC_STEPS + 40) @(posedge clk);

		$display("%0d ticks sent, %0d poses checked under %0d register settings",
			ticks_sent, board.checked_count, reg_settings);
		$display("covered heading wrap both ways, x held at its lower and y at its upper limit");
		if (board.mismatch_count == 0 && board.expected_poses.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ddo_pkg.sv
rtl/ddo_cordic.sv
rtl/ddo_datapath.sv
rtl/ddo_ctrl.sv
rtl/differential_drive_odometry.sv
rtl/ddo_checker.sv
verif/tb.sv
